FILE: rtl/fmdr_pkg.sv
// Package for the fraction multiply/divide/reduce block.
// Holds widths, the request and result payload types and shared helpers.
// No dependencies.
package fmdr_pkg;

  localparam int OperandWidth = 16;
  localparam int ProdWidth    = 2 * OperandWidth - 1;
  localparam int KWidth       = $clog2(ProdWidth);
  localparam int GcdSteps     = 2 * ProdWidth;
  localparam int OutWidth     = 32;

  typedef logic [OperandWidth-1:0] mag_t;
  typedef logic [ProdWidth-1:0]    prod_t;
  typedef logic [KWidth-1:0]       shift_t;

  localparam logic CmdMultiply = 1'b0;
  localparam logic CmdDivide   = 1'b1;

  typedef struct packed {
    logic                           command;
    logic signed [OperandWidth-1:0] a_num;
    logic signed [OperandWidth-1:0] a_den;
    logic signed [OperandWidth-1:0] b_num;
    logic signed [OperandWidth-1:0] b_den;
  } fmdr_req_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] res_num;
    logic signed [OutWidth-1:0] res_den;
    logic                       zero_error;
  } fmdr_res_t;

  // Sign and zero information that rides along with the data.
  typedef struct packed {
    logic neg_n;
    logic neg_d;
    logic zero;
  } fmdr_side_t;

  // Magnitude of a two's complement operand; the most negative value maps
  // to its unsigned magnitude, which still fits the same width.
  function automatic mag_t abs_mag(input logic [OperandWidth-1:0] x);
    mag_t r;
    r = x[OperandWidth-1] ? (~x + 1'b1) : x;
    return r;
  endfunction

  // Fit a magnitude to the output width and apply its sign.
  function automatic logic [OutWidth-1:0] pack_out(input logic neg, input prod_t q);
    logic [OutWidth+ProdWidth-1:0] wide;
    logic [OutWidth-1:0]           m;
    wide = {{OutWidth{1'b0}}, q};
    m    = wide[OutWidth-1:0];
    return neg ? (~m + 1'b1) : m;
  endfunction

endpackage

FILE: rtl/fraction_mul_div_reduce.sv
// Top level of the fraction multiply/divide/reduce block.
// Depends on fmdr_pkg and fmdr_divider.

// Multiplies (command 0) or divides (command 1) two signed 16-bit fractions
// and reduces the two cross products by the gcd of their magnitudes; each
// part keeps the sign of its own product. When both products are zero,
// zero_error is set and both parts are zero. The block is a fixed pipeline:
// one request can enter every cycle, and each result passes through the binary
// gcd (one step per stage) followed by the restoring dividers (one quotient
// bit per stage). A stall on the result side holds the whole pipeline.
module fraction_mul_div_reduce import fmdr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  fmdr_req_t req,
  output logic      res_valid,
  input  logic      res_stall,
  output fmdr_res_t res
);

  typedef struct packed {
    fmdr_side_t side;
    prod_t      pn;
    prod_t      pd;
    prod_t      u;
    prod_t      v;
    shift_t     k;
  } gcd_t;

  localparam int Depth = 3 + GcdSteps + ProdWidth;

  logic adv;
  logic [Depth-1:0] valid;

  // Whole pipeline moves when the output register is free or taken.
  assign adv       = !res_valid || !res_stall;
  assign req_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      valid     <= {valid[Depth-2:0], req_valid};
      res_valid <= valid[Depth-1];
    end
  end

  // Stage one: operand magnitudes, crossed for divide.
  mag_t x1, y1, x2, y2;
  logic neg_n1, neg_d1;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (req.command == CmdDivide) begin
        x1 <= abs_mag(req.a_num); y1 <= abs_mag(req.b_den);
        x2 <= abs_mag(req.a_den); y2 <= abs_mag(req.b_num);
        neg_n1 <= req.a_num[OperandWidth-1] ^ req.b_den[OperandWidth-1];
        neg_d1 <= req.a_den[OperandWidth-1] ^ req.b_num[OperandWidth-1];
      end else begin
        x1 <= abs_mag(req.a_num); y1 <= abs_mag(req.b_num);
        x2 <= abs_mag(req.a_den); y2 <= abs_mag(req.b_den);
        neg_n1 <= req.a_num[OperandWidth-1] ^ req.b_num[OperandWidth-1];
        neg_d1 <= req.a_den[OperandWidth-1] ^ req.b_den[OperandWidth-1];
      end
    end
  end

  // Stage two: the two products seed the gcd.
  logic [2*OperandWidth-1:0] prod_n, prod_d;
  gcd_t gs [GcdSteps+1];

  assign prod_n = x1 * y1;
  assign prod_d = x2 * y2;

  always_ff @(posedge clk) begin
    if (adv) begin
      gs[0].pn         <= prod_n[ProdWidth-1:0];
      gs[0].pd         <= prod_d[ProdWidth-1:0];
      gs[0].u          <= prod_n[ProdWidth-1:0];
      gs[0].v          <= prod_d[ProdWidth-1:0];
      gs[0].k          <= '0;
      gs[0].side.neg_n <= neg_n1 && (prod_n != '0);
      gs[0].side.neg_d <= neg_d1 && (prod_d != '0);
      gs[0].side.zero  <= (prod_n == '0) && (prod_d == '0);
    end
  end

  // Binary gcd, one step per stage; each step drops at least one bit
  // from u and v together until one of them reaches zero.
  genvar i;
  generate
    for (i = 0; i < GcdSteps; i++) begin : g_gcd
      gcd_t gs_next;
      always_comb begin
        gs_next = gs[i];
        if (gs[i].u == '0 || gs[i].v == '0) begin
          gs_next = gs[i];
        end else if (!gs[i].u[0] && !gs[i].v[0]) begin
          gs_next.u = gs[i].u >> 1;
          gs_next.v = gs[i].v >> 1;
          gs_next.k = gs[i].k + 1'b1;
        end else if (!gs[i].u[0]) begin
          gs_next.u = gs[i].u >> 1;
        end else if (!gs[i].v[0]) begin
          gs_next.v = gs[i].v >> 1;
        end else if (gs[i].u >= gs[i].v) begin
          gs_next.u = (gs[i].u - gs[i].v) >> 1;
        end else begin
          gs_next.v = (gs[i].v - gs[i].u) >> 1;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          gs[i+1] <= gs_next;
        end
      end
    end
  endgenerate

  // Rebuild the gcd; a zero divisor (both parts zero) is replaced by one.
  prod_t g_odd, g_full;
  prod_t dvd_n, dvd_d, dvs;
  fmdr_side_t side [ProdWidth+1];

  assign g_odd  = gs[GcdSteps].u | gs[GcdSteps].v;
  assign g_full = g_odd << gs[GcdSteps].k;

  always_ff @(posedge clk) begin
    if (adv) begin
      dvd_n   <= gs[GcdSteps].pn;
      dvd_d   <= gs[GcdSteps].pd;
      dvs     <= gs[GcdSteps].side.zero ? ProdWidth'(1) : g_full;
      side[0] <= gs[GcdSteps].side;
    end
  end

  // Divide both products by the gcd in matching pipelines.
  prod_t q_n, q_d;

  fmdr_divider u_div_num (
    .clk      (clk),
    .en       (adv),
    .dividend (dvd_n),
    .divisor  (dvs),
    .quotient (q_n)
  );

  fmdr_divider u_div_den (
    .clk      (clk),
    .en       (adv),
    .dividend (dvd_d),
    .divisor  (dvs),
    .quotient (q_d)
  );

  generate
    for (i = 0; i < ProdWidth; i++) begin : g_side
      always_ff @(posedge clk) begin
        if (adv) begin
          side[i+1] <= side[i];
        end
      end
    end
  endgenerate

  // Output register: apply signs, or report the both-zero case.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (side[ProdWidth].zero) begin
        res.res_num    <= '0;
        res.res_den    <= '0;
        res.zero_error <= 1'b1;
      end else begin
        res.res_num    <= pack_out(side[ProdWidth].neg_n, q_n);
        res.res_den    <= pack_out(side[ProdWidth].neg_d, q_d);
        res.zero_error <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/fmdr_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on fmdr_pkg for the product width.
module fmdr_divider import fmdr_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  prod_t dividend,
  input  prod_t divisor,
  output prod_t quotient
);

  typedef struct packed {
    prod_t rem;
    prod_t quo;
    prod_t dvd;
    prod_t dvs;
  } div_t;

  div_t stage [ProdWidth+1];

  assign stage[0] = '{rem: '0, quo: '0, dvd: dividend, dvs: divisor};

  genvar i;
  generate
    for (i = 0; i < ProdWidth; i++) begin : g_stage
      div_t             stage_next;
      logic [ProdWidth:0] trial;

      // Bring down the next dividend bit and subtract where it fits.
      always_comb begin
        trial      = {stage[i].rem, stage[i].dvd[ProdWidth-1]};
        stage_next = stage[i];
        stage_next.dvd = {stage[i].dvd[ProdWidth-2:0], 1'b0};
        if (trial >= {1'b0, stage[i].dvs}) begin
          stage_next.rem = ProdWidth'(trial - {1'b0, stage[i].dvs});
          stage_next.quo = {stage[i].quo[ProdWidth-2:0], 1'b1};
        end else begin
          stage_next.rem = trial[ProdWidth-1:0];
          stage_next.quo = {stage[i].quo[ProdWidth-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          stage[i+1] <= stage_next;
        end
      end
    end
  endgenerate

  assign quotient = stage[ProdWidth].quo;

endmodule

FILE: verif/fmdr_checker.sv
// Checker for the fraction multiply/divide/reduce block.
// Watches the request and result channels, predicts each result and compares.
// Depends on fmdr_pkg.
module fmdr_checker import fmdr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_stall,
  input  fmdr_req_t req,
  input  logic      res_valid,
  input  logic      res_stall,
  input  fmdr_res_t res,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  fmdr_res_t reduced_q[$];

  // Reduce the cross products of one request by the gcd of their magnitudes.
  function automatic fmdr_res_t reduce_fraction(input fmdr_req_t r);
    logic signed [OperandWidth-1:0] pn_x, pn_y, pd_x, pd_y;
    longint unsigned mn, md, g, x, y, t;
    logic neg_n, neg_d;
    fmdr_res_t o;
    if (r.command == CmdDivide) begin
      pn_x = r.a_num; pn_y = r.b_den; pd_x = r.a_den; pd_y = r.b_num;
    end else begin
      pn_x = r.a_num; pn_y = r.b_num; pd_x = r.a_den; pd_y = r.b_den;
    end
    mn = longint'(pn_x < 0 ? -longint'(pn_x) : longint'(pn_x)) *
         longint'(pn_y < 0 ? -longint'(pn_y) : longint'(pn_y));
    md = longint'(pd_x < 0 ? -longint'(pd_x) : longint'(pd_x)) *
         longint'(pd_y < 0 ? -longint'(pd_y) : longint'(pd_y));
    neg_n = ((pn_x < 0) != (pn_y < 0)) && (mn != 0);
    neg_d = ((pd_x < 0) != (pd_y < 0)) && (md != 0);
    if (mn == 0 && md == 0) begin
      o.res_num = '0;
      o.res_den = '0;
      o.zero_error = 1'b1;
      return o;
    end
    x = mn;
    y = md;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    g = x;
    mn = mn / g;
    md = md / g;
    o.res_num = neg_n ? -mn[31:0] : mn[31:0];
    o.res_den = neg_d ? -md[31:0] : md[31:0];
    o.zero_error = 1'b0;
    return o;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input fmdr_res_t got,
                                 input fmdr_res_t want);
    $display("%0t mismatch %s: got num=%0d den=%0d err=%0b, want num=%0d den=%0d err=%0b",
             $realtime, what, got.res_num, got.res_den, got.zero_error,
             want.res_num, want.res_den, want.zero_error);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Predict on each accepted request, compare on each accepted result.
  always @(posedge clk) begin
    fmdr_res_t want;
    if (!rst) begin
      if (req_valid && !req_stall) reduced_q.push_back(reduce_fraction(req));
      if (res_valid && !res_stall) begin
        if (reduced_q.size() == 0) begin
          report_mismatch("unexpected result", res, '0);
        end else begin
          want = reduced_q.pop_front();
          if (res.res_num !== want.res_num) report_mismatch("res_num", res, want);
          if (res.res_den !== want.res_den) report_mismatch("res_den", res, want);
          if (res.zero_error !== want.zero_error)
            report_mismatch("zero_error", res, want);
        end
      end
    end
    pending = reduced_q.size();
  end
endmodule

FILE: verif/tb_fraction_mul_div_reduce.sv
// Testbench top for the fraction multiply/divide/reduce block.
// Drives directed and random requests, stalls results and gives the verdict.
// Depends on fmdr_pkg, fraction_mul_div_reduce and fmdr_checker.
module tb_fraction_mul_div_reduce import fmdr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomCount = 800;
  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  fmdr_req_t req = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  fmdr_res_t res;
  int        fail_count;
  int        pending;
  int        idle_cycles = 0;
  logic      sending = 1'b1;

  always #10 clk = ~clk;

  fraction_mul_div_reduce dut (.*);

  fmdr_checker checker_i (.*);

  // Gap length: none half the time, otherwise mostly short, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Operand picked to favor extremes, zero and common factors.
  function automatic logic [OperandWidth-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3: return 16'hffff;
      4: return 16'(($urandom_range(0, 255) - 128) * (1 << $urandom_range(0, 7)));
      5: return 16'($urandom_range(0, 40)) - 16'd20;
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one request and hold it until it is accepted.
  task automatic send_request(input logic cmd, input logic [15:0] an,
                              input logic [15:0] ad, input logic [15:0] bn,
                              input logic [15:0] bd);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{command: cmd, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // Random stalls on the result side.
  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      res_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        res_stall <= 1'b1;
        repeat (g) @(negedge clk);
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall) || rst ||
        (!sending && pending == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("fraction_mul_div_reduce verification failed");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: extremes, both commands, zero products, signs.
    send_request(CmdMultiply, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(CmdDivide,   16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_request(CmdMultiply, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(CmdMultiply, 16'd0, 16'd0, 16'd5, 16'd7);
    send_request(CmdDivide,   16'd0, 16'd3, 16'd0, 16'd4);
    send_request(CmdMultiply, 16'd0, 16'd3, 16'd4, 16'd5);
    send_request(CmdMultiply, 16'd3, 16'd0, 16'd4, 16'd5);
    send_request(CmdDivide,   16'd3, 16'd4, 16'd0, 16'd5);
    send_request(CmdDivide,   16'd0, 16'd4, 16'd7, 16'd5);
    send_request(CmdMultiply, -16'sd6, 16'sd4, 16'sd2, -16'sd9);
    send_request(CmdDivide,   -16'sd6, -16'sd4, -16'sd2, -16'sd9);
    send_request(CmdMultiply, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_request(CmdDivide,   16'h5555, 16'haaaa, 16'h1234, 16'hedcb);
    send_request(CmdMultiply, 16'd1, 16'd1, 16'd1, 16'd1);
    send_request(CmdDivide,   16'h8000, 16'd1, 16'd1, 16'h8000);
    // Random part.
    for (n = 0; n < RandomCount; n++)
      send_request(1'($urandom_range(0, 1)), pick_operand(), pick_operand(),
                   pick_operand(), pick_operand());
    req_valid <= 1'b0;
    sending <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0)
      $display("fraction_mul_div_reduce verification clean");
    else
      $display("fraction_mul_div_reduce verification failed");
    $finish;
  end
endmodule
